>>> hdl/bsem_pkg.sv
`default_nettype none

package bsem_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int TASK_ID_BITS = 8;
    localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

    typedef logic [TASK_ID_BITS-1:0] t_task;
    typedef logic [PTR_W-1:0]        t_ptr;
    typedef logic [CNT_W-1:0]        t_cnt;

    typedef enum logic [2:0] {
        ST_ACQUIRED  = 3'd0,
        ST_BLOCKED   = 3'd1,
        ST_FULL      = 3'd2,
        ST_FREED     = 3'd3,
        ST_HANDOVER  = 3'd4,
        ST_NOT_OWNER = 3'd5
    } t_status;

    typedef enum logic {
        OP_DOWN = 1'b0,
        OP_UP   = 1'b1
    } t_op;

    typedef struct packed {
        t_op   kind;
        t_task task_id;
    } t_in;

    typedef struct packed {
        t_status status;
        t_task   woken_task;
        logic    owner_valid;
        t_task   owner_id;
        t_cnt    waiting_count;
    } t_out;

endpackage

`default_nettype wire

>>> hdl/binary_semaphore_with_wait_queue.sv
// Binary semaphore with an owner register and a FIFO of up to QUEUE_DEPTH waiting task ids.
// Each request is accepted, then committed: the accept cycle reads the head slot of the wait
// memory (synchronous read); the commit in S_EXEC decides, updates the owner, pointers and
// count, writes the tail slot and loads the result register. That commit waits while the
// result register holds a beat the consumer has not taken; a new request is taken only once
// the previous one has committed. A config write (only while idle) reloads the free bit and
// empties owner and queue; it is taken whenever no request is in flight.
`default_nettype none

module binary_semaphore_with_wait_queue
    import bsem_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data,
    input  wire logic i_cfg_valid,
    output logic      o_cfg_ready,
    input  wire logic i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    t_in    r_item;
    logic   r_free, n_free;
    logic   r_has_owner, n_has_owner;
    t_task  r_owner, n_owner;
    t_ptr   r_head, n_head;
    t_ptr   r_tail, n_tail;
    t_cnt   r_count, n_count;
    logic   r_out_valid, n_out_valid;
    t_out   r_out, n_out;

    t_task  r_mem [QUEUE_DEPTH];
    t_task  r_rd_data;
    logic   w_mem_we;
    logic   w_accept;
    logic   w_commit;
    logic   w_cfg;

    function automatic t_ptr ptr_inc(input t_ptr p);
        if (p == t_ptr'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + t_ptr'(1);
    endfunction

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_cfg    = i_cfg_valid && (r_state == S_IDLE);
    assign w_commit = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_free      = r_free;
        n_has_owner = r_has_owner;
        n_owner     = r_owner;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_mem_we    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_cfg) begin
                    n_free      = i_cfg_data;
                    n_has_owner = 1'b0;
                    n_owner     = '0;
                    n_head      = '0;
                    n_tail      = '0;
                    n_count     = '0;
                end
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_commit) begin
                    n_state          = S_IDLE;
                    n_out_valid      = 1'b1;
                    n_out.woken_task = '0;
                    if (r_item.kind == OP_DOWN) begin
                        priority if (r_free) begin
                            n_free       = 1'b0;
                            n_has_owner  = 1'b1;
                            n_owner      = r_item.task_id;
                            n_out.status = ST_ACQUIRED;
                        end else if (r_count == t_cnt'(QUEUE_DEPTH)) begin
                            n_out.status = ST_FULL;
                        end else begin
                            w_mem_we     = 1'b1;
                            n_tail       = ptr_inc(r_tail);
                            n_count      = r_count + t_cnt'(1);
                            n_out.status = ST_BLOCKED;
                        end
                    end else begin
                        priority if (r_has_owner && (r_owner != r_item.task_id)) begin
                            n_out.status = ST_NOT_OWNER;
                        end else if (r_count == '0) begin
                            n_free       = 1'b1;
                            n_has_owner  = 1'b0;
                            n_owner      = '0;
                            n_out.status = ST_FREED;
                        end else begin
                            // head slot was read during the accept cycle
                            n_head           = ptr_inc(r_head);
                            n_count          = r_count - t_cnt'(1);
                            n_free           = 1'b0;
                            n_has_owner      = 1'b1;
                            n_owner          = r_rd_data;
                            n_out.woken_task = r_rd_data;
                            n_out.status     = ST_HANDOVER;
                        end
                    end
                    n_out.owner_valid   = n_has_owner;
                    n_out.owner_id      = n_has_owner ? n_owner : '0;
                    n_out.waiting_count = n_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= 1'b1;
            r_has_owner <= 1'b0;
            r_owner     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_has_owner <= n_has_owner;
            r_owner     <= n_owner;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_accept) begin
            r_item <= i_in_data;
        end
    end

    // wait queue storage, one write and one read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_tail] <= r_item.task_id;
        end
        r_rd_data <= r_mem[r_head];
    end

endmodule

`default_nettype wire

>>> hdl/bsem_checker.sv
`default_nettype none

module bsem_checker
    import bsem_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result beat changed while stalled");

    a_owner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.owner_valid) |-> (o_out_data.owner_id == '0))
        else $error("owner id set without an owner");

    a_handover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_HANDOVER)) |->
            (o_out_data.owner_valid && (o_out_data.owner_id == o_out_data.woken_task)))
        else $error("handover does not name the woken task as owner");

    a_woken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_HANDOVER)) |->
            (o_out_data.woken_task == '0))
        else $error("woken task set outside a handover");

    a_freed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_FREED)) |->
            (!o_out_data.owner_valid && (o_out_data.waiting_count == '0)))
        else $error("release to free left an owner or waiters");

endmodule

bind binary_semaphore_with_wait_queue bsem_checker u_bsem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
